/* rtl/far_pkg.sv */
// Shared types for the fraction add and reduce block.
package far_pkg;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL   = 7'b0000010,
      ST_ADD   = 7'b0000100,
      ST_GCD   = 7'b0001000,
      ST_DIVN  = 7'b0010000,
      ST_DIVD  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

endpackage

/* rtl/fraction_add_reduce_top.sv */
// Top level of the fraction add and reduce block.
// A request is taken when start is high and busy low; busy then stays high
// until the result strobe. The shared multiplier forms the three products and
// an add forms the raw sum; then each Euclid remainder step and each of the
// two final divisions run on one shared bit-serial divider. A 0/0 sum skips
// the divisions. rsp_valid pulses for one cycle with the result; it cannot
// be held off.
module fraction_add_reduce_top #(
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [WIDTH-1:0]  req_a_num,
   input  logic signed [WIDTH-1:0]  req_a_den,
   input  logic signed [WIDTH-1:0]  req_b_num,
   input  logic signed [WIDTH-1:0]  req_b_den,
   output logic                     rsp_valid,
   output logic signed [WIDTH-1:0]  rsp_sum_num,
   output logic signed [WIDTH-1:0]  rsp_sum_den,
   output logic                     rsp_overflow,
   output logic                     rsp_zero_divisor
);

   far_pkg::div_ctl_type div_ctl;
   logic             div_done;
   logic [WIDTH-1:0] div_dividend, div_divisor, div_quotient, div_remainder;

   far_ctrl #(.WIDTH(WIDTH)) u_ctrl (
      .clock, .reset, .start,
      .a_num(req_a_num), .a_den(req_a_den), .b_num(req_b_num), .b_den(req_b_den),
      .busy, .div_ctl_o(div_ctl), .div_done,
      .div_dividend, .div_divisor, .div_quotient, .div_remainder,
      .rsp_valid, .rsp_sum_num, .rsp_sum_den, .rsp_overflow, .rsp_zero_divisor
   );

   far_div #(.WIDTH(WIDTH)) u_div (
      .clock, .reset, .start(div_ctl.start),
      .dividend(div_dividend), .divisor(div_divisor),
      .done(div_done), .quotient(div_quotient), .remainder(div_remainder)
   );

endmodule

/* rtl/far_div.sv */
// Shared restoring divider on magnitudes, one quotient bit per cycle.
module far_div #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDTH-1:0]     dividend,
   input  logic [WIDTH-1:0]     divisor,
   output logic                 done,
   output logic [WIDTH-1:0]     quotient,
   output logic [WIDTH-1:0]     remainder
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[WIDTH-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/far_ctrl.sv */
// Sequencer: products, sum, Euclid loop and final divisions on the divider.
module far_ctrl #(
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WIDTH-1:0]  a_num,
   input  logic signed [WIDTH-1:0]  a_den,
   input  logic signed [WIDTH-1:0]  b_num,
   input  logic signed [WIDTH-1:0]  b_den,
   output logic                     busy,
   output far_pkg::div_ctl_type     div_ctl_o,
   input  logic                     div_done,
   output logic [WIDTH-1:0]         div_dividend,
   output logic [WIDTH-1:0]         div_divisor,
   input  logic [WIDTH-1:0]         div_quotient,
   input  logic [WIDTH-1:0]         div_remainder,
   output logic                     rsp_valid,
   output logic signed [WIDTH-1:0]  rsp_sum_num,
   output logic signed [WIDTH-1:0]  rsp_sum_den,
   output logic                     rsp_overflow,
   output logic                     rsp_zero_divisor
);

   localparam logic [WIDTH-1:0] MINV = {1'b1, {(WIDTH-1){1'b0}}};

   far_pkg::state_type state_ff, state_in;
   logic [1:0]              mcnt_ff, mcnt_in;
   logic signed [WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [WIDTH-1:0] an_in, ad_in, bn_in, bd_in;
   logic signed [WIDTH-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic signed [WIDTH-1:0] n_ff, n_in, d_ff, d_in;
   logic signed [WIDTH-1:0] u_ff, u_in, v_ff, v_in;
   logic signed [WIDTH-1:0] qn_ff, qn_in;
   logic                    ovf_ff, ovf_in;
   logic                    pend_ff, pend_in;
   logic                    dstart;
   logic                    vld_ff, vld_in;
   logic signed [WIDTH-1:0] on_ff, on_in, od_ff, od_in;
   logic                    oo_ff, oo_in, oz_ff, oz_in;

   logic signed [WIDTH-1:0]   ma, mb;
   logic signed [2*WIDTH-1:0] prod;
   logic                      pover;
   logic signed [WIDTH-1:0]   sum;
   logic [WIDTH-1:0]          ua, va, qmag, rmag;
   logic                      qneg;
   logic signed [WIDTH-1:0]   qsig;
   logic                      qover;

   function automatic logic [WIDTH-1:0] magof(input logic [WIDTH-1:0] x);
      magof = x[WIDTH-1] ? (~x + 1'b1) : x;
   endfunction

   // one multiplier, shared by the three products
   always_comb begin
      case (mcnt_ff)
         2'd0:    begin ma = an_ff; mb = bd_ff; end
         2'd1:    begin ma = ad_ff; mb = bn_ff; end
         default: begin ma = ad_ff; mb = bd_ff; end
      endcase
      prod  = ma * mb;
      pover = prod != {{WIDTH{prod[WIDTH-1]}}, prod[WIDTH-1:0]};
      sum   = p1_ff + p2_ff;
      rmag  = div_remainder;
      qmag  = div_quotient;
      qsig  = qneg ? -$signed(qmag) : $signed(qmag);
      qover = qneg ? (qmag > MINV) : qmag[WIDTH-1];
   end

   always_comb begin
      state_in = state_ff;
      mcnt_in  = mcnt_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      p1_in = p1_ff; p2_in = p2_ff; n_in = n_ff; d_in = d_ff;
      u_in = u_ff; v_in = v_ff; qn_in = qn_ff;
      ovf_in  = ovf_ff;
      pend_in = 1'b0;
      dstart  = 1'b0;
      ua = magof(u_ff);
      va = magof(v_ff);
      qneg = 1'b0;
      div_dividend = ua;
      div_divisor  = va;
      vld_in = 1'b0;
      on_in = on_ff; od_in = od_ff; oo_in = oo_ff; oz_in = oz_ff;
      case (state_ff)
         far_pkg::ST_IDLE: begin
            if (start) begin
               an_in = a_num; ad_in = a_den; bn_in = b_num; bd_in = b_den;
               mcnt_in  = 2'd0;
               ovf_in   = 1'b0;
               state_in = far_pkg::ST_MUL;
            end
         end
         far_pkg::ST_MUL: begin
            if (pover) ovf_in = 1'b1;
            mcnt_in = mcnt_ff + 1'b1;
            case (mcnt_ff)
               2'd0:    p1_in = prod[WIDTH-1:0];
               2'd1:    p2_in = prod[WIDTH-1:0];
               default: begin
                  d_in     = prod[WIDTH-1:0];
                  state_in = far_pkg::ST_ADD;
               end
            endcase
         end
         far_pkg::ST_ADD: begin
            n_in = sum;
            if (p1_ff[WIDTH-1] == p2_ff[WIDTH-1] && sum[WIDTH-1] != p1_ff[WIDTH-1])
               ovf_in = 1'b1;
            u_in = sum;
            v_in = d_ff;
            state_in = far_pkg::ST_GCD;
         end
         far_pkg::ST_GCD: begin
            // run one remainder step per divider pass
            if (div_done) begin
               u_in = v_ff;
               v_in = u_ff[WIDTH-1] ? -$signed(rmag) : $signed(rmag);
            end else if (!pend_ff && !div_done) begin
               if (v_ff == '0) begin
                  if (u_ff == '0) begin
                     vld_in = 1'b1;
                     on_in = '0; od_in = '0; oo_in = ovf_ff; oz_in = 1'b1;
                     state_in = far_pkg::ST_IDLE;
                  end else begin
                     // launch n / g
                     div_dividend = magof(n_ff);
                     div_divisor  = ua;
                     dstart  = 1'b1;
                     pend_in = 1'b1;
                     state_in = far_pkg::ST_DIVN;
                  end
               end else begin
                  dstart  = 1'b1;
                  pend_in = 1'b1;
               end
            end else begin
               pend_in = pend_ff;
            end
            if (div_done) pend_in = 1'b0;
         end
         far_pkg::ST_DIVN: begin
            div_dividend = magof(n_ff);
            div_divisor  = ua;
            qneg = n_ff[WIDTH-1] != u_ff[WIDTH-1];
            if (div_done) begin
               qn_in = qsig;
               if (qover) ovf_in = 1'b1;
               // launch d / g
               div_dividend = magof(d_ff);
               dstart = 1'b1;
               state_in = far_pkg::ST_DIVD;
            end
         end
         far_pkg::ST_DIVD: begin
            div_dividend = magof(d_ff);
            div_divisor  = ua;
            qneg = d_ff[WIDTH-1] != u_ff[WIDTH-1];
            if (div_done) begin
               vld_in = 1'b1;
               on_in = qn_ff; od_in = qsig;
               oo_in = ovf_ff | qover; oz_in = 1'b0;
               state_in = far_pkg::ST_IDLE;
            end
         end
         default: state_in = far_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      p1_ff <= p1_in; p2_ff <= p2_in; n_ff <= n_in; d_ff <= d_in;
      u_ff <= u_in; v_ff <= v_in; qn_ff <= qn_in;
      ovf_ff <= ovf_in; mcnt_ff <= mcnt_in;
      on_ff <= on_in; od_ff <= od_in; oo_ff <= oo_in; oz_ff <= oz_in;
      if (reset) begin
         state_ff <= far_pkg::ST_IDLE;
         pend_ff  <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         vld_ff   <= vld_in;
      end
   end

   assign busy             = state_ff != far_pkg::ST_IDLE;
   assign div_ctl_o.start  = dstart;
   assign div_ctl_o.done   = div_done;
   assign rsp_valid        = vld_ff;
   assign rsp_sum_num      = on_ff;
   assign rsp_sum_den      = od_ff;
   assign rsp_overflow     = oo_ff;
   assign rsp_zero_divisor = oz_ff;

endmodule

/* rtl/far_checker.sv */
// Port-level checks for the fraction add and reduce block.
module far_checker #(
   parameter int WIDTH = 32
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic             rsp_zero_divisor,
   input logic [WIDTH-1:0] rsp_sum_num,
   input logic [WIDTH-1:0] rsp_sum_den
);

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("start not taken");

   a_valid_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("strobe while busy");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_divisor |-> rsp_sum_num == '0 && rsp_sum_den == '0)
      else $error("zero divisor result not 0/0");

endmodule

bind fraction_add_reduce_top far_checker #(.WIDTH(WIDTH)) u_far_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_zero_divisor,
   .rsp_sum_num, .rsp_sum_den
);
